// ===== hdl/sha256_stream_hasher_assert.svh =====
// assertion macros for the sha-256 stream hasher
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("sha assertion failed");
`define SHA_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("sha assertion failed");
`else
`define SHA_ASSERT_IMPL(label, a, c)
`define SHA_ASSERT_NEXT(label, a, c)
`endif
`endif

// ===== hdl/sha_pkg.sv =====
// shared constants and the rotr function for the sha-256 stream hasher
package sha_pkg;
	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LengthPos = 56;
	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [0:0] FuncAbsorb = 1'b0;
	localparam logic [0:0] FuncFinish = 1'b1;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage

// ===== hdl/sha_core.sv =====
// sha-256 compression: one round per cycle, schedule in a 16-word window
module sha_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                done,
	output logic [3:0]          wrd_addr,
	input  logic [31:0]         wrd_data,
	input  logic [255:0]        h_in,
	output logic [255:0]        h_out
);
	logic [5:0] rnd_q;
	logic       run_q;
	logic       load_q;
	logic       done_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] w_q [16];
	logic [31:0] wt, s0, s1, t1, t2, ch, mj, ep0, ep1;
	logic [5:0]  ri;

	// word address: fetch the word of the next round, for rounds 0..15
	assign wrd_addr = run_q ? (rnd_q[3:0] + 4'd1) : 4'd0;
	assign ri = rnd_q;

	always_comb begin
		s0 = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wt = (ri < 6'd16) ? wrd_data : (w_q[0] + s0 + w_q[9] + s1);
		ep1 = sha_pkg::rotr(e_q, 6) ^ sha_pkg::rotr(e_q, 11) ^ sha_pkg::rotr(e_q, 25);
		ch = (e_q & f_q) ^ (~e_q & g_q);
		t1 = h_q + ep1 + ch + sha_pkg::RoundK[ri] + wt;
		ep0 = sha_pkg::rotr(a_q, 2) ^ sha_pkg::rotr(a_q, 13) ^ sha_pkg::rotr(a_q, 22);
		mj = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t2 = ep0 + mj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			load_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !run_q && !load_q) begin
				load_q <= 1'b1;
				rnd_q <= '0;
			end else if (load_q) begin
				load_q <= 1'b0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (ri == 6'd63) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
				rnd_q <= rnd_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_q) begin
			a_q <= h_in[255:224]; b_q <= h_in[223:192]; c_q <= h_in[191:160];
			d_q <= h_in[159:128]; e_q <= h_in[127:96];  f_q <= h_in[95:64];
			g_q <= h_in[63:32];   h_q <= h_in[31:0];
		end else if (run_q) begin
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wt;
		end
	end

	assign done = done_q;
	assign h_out = {h_in[255:224] + a_q, h_in[223:192] + b_q, h_in[191:160] + c_q,
		h_in[159:128] + d_q, h_in[127:96] + e_q, h_in[95:64] + f_q,
		h_in[63:32] + g_q, h_in[31:0] + h_q};
endmodule

// ===== hdl/sha_buf.sv =====
// block buffer memory: byte writes, 32-bit big-endian word reads
module sha_buf (
	input  logic        clk,
	input  logic        we,
	input  logic [5:0]  waddr,
	input  logic [7:0]  wdata,
	input  logic [3:0]  raddr,
	output logic [31:0] rdata
);
	logic [7:0] mem0 [16];
	logic [7:0] mem1 [16];
	logic [7:0] mem2 [16];
	logic [7:0] mem3 [16];
	logic [31:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			case (waddr[1:0])
				2'd0: mem0[waddr[5:2]] <= wdata;
				2'd1: mem1[waddr[5:2]] <= wdata;
				2'd2: mem2[waddr[5:2]] <= wdata;
				default: mem3[waddr[5:2]] <= wdata;
			endcase
		end
		rd_q <= {mem0[raddr], mem1[raddr], mem2[raddr], mem3[raddr]};
	end

	assign rdata = rd_q;
endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// sha-256 stream hasher top level
// absorb requests are taken while idle; every 64th byte starts a compression that
// stalls requests through start, load, 64 rounds and write-back.
// finish pads byte by byte (mark, zero bytes, length, plus compressions), then
// emits eight digest words, one per cycle when the output is not stalled.
// asynchronous active-low reset restores initial hash values and clears counts.
`include "sha256_stream_hasher_assert.svh"
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [0:0]  func,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_COMP, ST_PAD, ST_LEN, ST_OUT
	} state_t;

	state_t       state_q;
	logic [5:0]   cnt_q;
	logic [60:0]  msg_q;
	logic [63:0]  len_q;
	logic [2:0]   li_q;
	logic         fin_q;
	logic [255:0] hash_q;
	logic [255:0] h_new;
	logic [2:0]   oi_q;
	logic         ov_q;
	logic         comp_go_q;
	logic         core_done;
	logic         we;
	logic [7:0]   wdata;
	logic [3:0]   raddr;
	logic [31:0]  rdata;
	logic         acc;

	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		we = 1'b0;
		wdata = data_byte;
		case (state_q)
			ST_IDLE: begin
				we = acc;
				wdata = (func == sha_pkg::FuncAbsorb) ? data_byte : sha_pkg::PadMark;
			end
			ST_PAD: begin
				we = 1'b1;
				wdata = 8'h00;
			end
			ST_LEN: begin
				we = 1'b1;
				wdata = len_q[63:56];
			end
			default: we = 1'b0;
		endcase
	end

	sha_buf u_buf (
		.clk(clk), .we(we), .waddr(cnt_q), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// the core starts on the cycle after a block fills
	sha_core u_core (
		.clk(clk), .arst_n(arst_n), .start(comp_go_q), .done(core_done),
		.wrd_addr(raddr), .wrd_data(rdata), .h_in(hash_q), .h_out(h_new)
	);

	// next phase after a pad byte lands at cnt_q
	function automatic state_t after_pad(input logic [5:0] c);
		after_pad = (c == 6'd55) ? ST_LEN : ST_PAD;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			msg_q <= '0;
			len_q <= '0;
			li_q <= '0;
			fin_q <= 1'b0;
			oi_q <= '0;
			ov_q <= 1'b0;
			comp_go_q <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[255 - 32 * i -: 32] <= sha_pkg::InitH[i];
		end else begin
			comp_go_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						cnt_q <= cnt_q + 6'd1;
						if (func == sha_pkg::FuncAbsorb) begin
							msg_q <= msg_q + 61'd1;
							if (cnt_q == 6'd63) begin
								state_q <= ST_COMP;
								comp_go_q <= 1'b1;
								fin_q <= 1'b0;
							end
						end else begin
							len_q <= {msg_q, 3'b000};
							li_q <= '0;
							fin_q <= 1'b1;
							if (cnt_q == 6'd63) begin
								state_q <= ST_COMP;
								comp_go_q <= 1'b1;
							end else begin
								state_q <= after_pad(cnt_q);
							end
						end
					end
				end
				ST_PAD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_COMP;
						comp_go_q <= 1'b1;
					end else begin
						state_q <= after_pad(cnt_q);
					end
				end
				ST_LEN: begin
					cnt_q <= cnt_q + 6'd1;
					len_q <= {len_q[55:0], 8'h00};
					if (li_q == 3'd7) begin
						state_q <= ST_COMP;
						comp_go_q <= 1'b1;
						fin_q <= 1'b1;
					end else begin
						li_q <= li_q + 3'd1;
					end
				end
				ST_COMP: begin
					if (core_done) begin
						hash_q <= h_new;
						if (!fin_q) begin
							state_q <= ST_IDLE;
						end else if (li_q == 3'd7) begin
							state_q <= ST_OUT;
							oi_q <= '0;
							ov_q <= 1'b1;
						end else begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_OUT: begin
					if (ov_q && !out_stall) begin
						oi_q <= oi_q + 3'd1;
						if (oi_q == 3'd7) begin
							ov_q <= 1'b0;
							state_q <= ST_IDLE;
							cnt_q <= '0;
							msg_q <= '0;
							fin_q <= 1'b0;
							li_q <= '0;
							for (int i = 0; i < 8; i++)
								hash_q[255 - 32 * i -: 32] <= sha_pkg::InitH[i];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign digest_word = hash_q[255 - 32 * oi_q -: 32];
	assign word_index = oi_q;
	assign last = (oi_q == 3'd7);

	`SHA_ASSERT_IMPL(a_stall_busy, state_q == ST_COMP, in_stall)
	`SHA_ASSERT_IMPL(a_out_only_out, out_valid, state_q == ST_OUT)
	`SHA_ASSERT_NEXT(a_last_ends, out_valid && last && !out_stall, state_q == ST_IDLE)
endmodule
